@@ src/hrhp_pkg.sv @@
// Shared beat types, section and error codes, and match tables for the request head parser.
`default_nettype none

package hrhp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] section;
    logic [7:0] header_index;
    logic       field_start;
    logic [2:0] error_code;
    logic       request_done;
  } out_t;

  localparam int unsigned LimitW = 9;
  localparam logic [LimitW-1:0] HdrLimitReset = 9'd256;

  localparam logic [2:0] SecMethod  = 3'd0;
  localparam logic [2:0] SecPath    = 3'd1;
  localparam logic [2:0] SecVersion = 3'd2;
  localparam logic [2:0] SecHeader  = 3'd3;
  localparam logic [2:0] SecBody    = 3'd4;
  localparam logic [2:0] SecDelim   = 3'd5;

  localparam logic [2:0] ErrNone       = 3'd0;
  localparam logic [2:0] ErrMethod     = 3'd1;
  localparam logic [2:0] ErrPath       = 3'd2;
  localparam logic [2:0] ErrVersion    = 3'd3;
  localparam logic [2:0] ErrIncomplete = 3'd4;
  localparam logic [2:0] ErrTooMany    = 3'd5;

  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;

  localparam int unsigned NumMethods = 6;
  localparam int unsigned MethOptions = 4;

  localparam logic [7:0] MethodText [NumMethods][8] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // GET
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},  // POST
    '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // PUT
    '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00},  // DELETE
    '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h00},  // OPTIONS
    '{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00}   // HEAD
  };

  localparam logic [3:0] MethodLen [NumMethods] = '{
    4'd3, 4'd4, 4'd3, 4'd6, 4'd7, 4'd4
  };

  localparam logic [7:0] VersionText [8] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31  // HTTP/1.1
  };

endpackage

`default_nettype wire

@@ src/hrhp_parser.sv @@
// Per-byte parse state and tagging logic for the request head parser.
`default_nettype none

module hrhp_parser import hrhp_pkg::*; #(
  parameter int unsigned MAX_HEADER_COUNT = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire in_t               item_i,
  input  wire logic [LimitW-1:0] header_limit_i,
  output      out_t              res_o
);

  localparam int unsigned CntW = $clog2(MAX_HEADER_COUNT + 1);
  localparam logic [LimitW-1:0] MaxCnt = LimitW'(MAX_HEADER_COUNT);

  typedef enum logic [2:0] {
    PhMethod  = 3'd0,
    PhPath    = 3'd1,
    PhVersion = 3'd2,
    PhHeader  = 3'd3,
    PhBody    = 3'd4,
    PhDiscard = 3'd5
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [NumMethods-1:0] cand_q, cand_d;
  logic [3:0]            pos_q, pos_d;
  logic                  is_opt_q, is_opt_d;
  logic [1:0]            path_kind_q, path_kind_d;
  logic                  saw_cr_q, saw_cr_d;
  logic                  line_empty_q, line_empty_d;
  logic [CntW-1:0]       hdr_cnt_q, hdr_cnt_d;
  logic [2:0]            err_q, err_d;

  logic [NumMethods-1:0] cand_keep;
  logic                  method_ok;
  logic [LimitW-1:0]     eff_limit;
  logic [LimitW-1:0]     cnt_ext;
  logic                  limit_hit;
  logic [3:0]            pos_v;
  logic                  ver_match;
  logic                  le_mid;
  logic [2:0]            sec;
  logic                  fs;
  logic                  in_hdr;
  logic [2:0]            err_n;
  logic [7:0]            b;
  logic                  last;

  assign b    = item_i.in_byte;
  assign last = item_i.in_last;

  // Narrow the candidate set by the byte at the current position of each method.
  always_comb begin
    cand_keep = '0;
    method_ok = 1'b0;
    for (int i = 0; i < NumMethods; i++) begin
      cand_keep[i] = (pos_q < MethodLen[i]) && (b == MethodText[i][pos_q[2:0]]);
      if (cand_q[i] && (MethodLen[i] == pos_q)) begin
        method_ok = 1'b1;
      end
    end
  end

  assign eff_limit = (header_limit_i > MaxCnt) ? MaxCnt : header_limit_i;
  assign cnt_ext   = LimitW'(hdr_cnt_q);
  assign limit_hit = (cnt_ext >= eff_limit);

  // A pending CR that is not followed by LF spoils the version string.
  assign pos_v     = saw_cr_q ? 4'hF : pos_q;
  assign ver_match = !pos_v[3] && (b == VersionText[pos_v[2:0]]);

  // A CR that turned out to be content makes the header line non-empty.
  assign le_mid = saw_cr_q ? 1'b0 : line_empty_q;

  always_comb begin
    phase_d      = phase_q;
    cand_d       = cand_q;
    pos_d        = pos_q;
    is_opt_d     = is_opt_q;
    path_kind_d  = path_kind_q;
    saw_cr_d     = saw_cr_q;
    line_empty_d = line_empty_q;
    hdr_cnt_d    = hdr_cnt_q;
    err_n        = err_q;
    sec          = SecDelim;
    fs           = 1'b0;
    in_hdr       = 1'b0;

    case (phase_q)
      PhMethod: begin
        if (b == ChSp) begin
          if (method_ok) begin
            is_opt_d = cand_q[MethOptions] && (pos_q == 4'd7);
            phase_d  = PhPath;
            pos_d    = '0;
          end else begin
            err_n   = ErrMethod;
            phase_d = PhDiscard;
          end
        end else begin
          sec    = SecMethod;
          fs     = (pos_q == '0);
          cand_d = cand_q & cand_keep;
          if (pos_q != 4'hF) begin
            pos_d = pos_q + 4'd1;
          end
        end
      end
      PhPath: begin
        if (b == ChSp) begin
          if ((path_kind_q == 2'd1) || ((path_kind_q == 2'd2) && is_opt_q)) begin
            phase_d  = PhVersion;
            pos_d    = '0;
            saw_cr_d = 1'b0;
          end else begin
            err_n   = ErrPath;
            phase_d = PhDiscard;
          end
        end else begin
          sec = SecPath;
          fs  = (path_kind_q == 2'd0);
          if (path_kind_q == 2'd0) begin
            path_kind_d = (b == ChSlash) ? 2'd1 : (b == ChStar) ? 2'd2 : 2'd3;
          end else if (path_kind_q == 2'd2) begin
            path_kind_d = 2'd3;
          end
        end
      end
      PhVersion: begin
        if (saw_cr_q && (b == ChLf)) begin
          saw_cr_d = 1'b0;
          if (pos_q == 4'd8) begin
            phase_d      = PhHeader;
            line_empty_d = 1'b1;
          end else begin
            err_n   = ErrVersion;
            phase_d = PhDiscard;
          end
        end else if (b == ChCr) begin
          saw_cr_d = 1'b1;
          pos_d    = pos_v;
        end else begin
          saw_cr_d = 1'b0;
          sec      = SecVersion;
          fs       = (pos_v == '0);
          pos_d    = ver_match ? (pos_v + 4'd1) : 4'hF;
        end
      end
      PhHeader: begin
        if (saw_cr_q && (b == ChLf)) begin
          saw_cr_d = 1'b0;
          if (line_empty_q) begin
            phase_d = PhBody;
          end else begin
            hdr_cnt_d = hdr_cnt_q + CntW'(1);
          end
          line_empty_d = 1'b1;
        end else if (saw_cr_q && line_empty_q && limit_hit) begin
          // The stray CR opened a header line beyond the limit.
          saw_cr_d = 1'b0;
          err_n    = ErrTooMany;
          phase_d  = PhDiscard;
        end else begin
          line_empty_d = le_mid;
          if (b == ChCr) begin
            saw_cr_d = 1'b1;
          end else begin
            saw_cr_d = 1'b0;
            fs       = le_mid;
            if (le_mid && limit_hit) begin
              err_n   = ErrTooMany;
              phase_d = PhDiscard;
            end else begin
              line_empty_d = 1'b0;
              sec          = SecHeader;
              in_hdr       = 1'b1;
            end
          end
        end
      end
      PhBody: begin
        sec          = SecBody;
        fs           = line_empty_q;
        line_empty_d = 1'b0;
      end
      default: begin
      end
    endcase

    if (phase_d == PhDiscard) begin
      sec    = SecDelim;
      fs     = 1'b0;
      in_hdr = 1'b0;
    end
    if (last && (err_n == ErrNone) && (phase_d < PhBody)) begin
      err_n = ErrIncomplete;
    end

    err_d = err_n;
    if (last) begin
      phase_d      = PhMethod;
      cand_d       = '1;
      pos_d        = '0;
      is_opt_d     = 1'b0;
      path_kind_d  = 2'd0;
      saw_cr_d     = 1'b0;
      line_empty_d = 1'b1;
      hdr_cnt_d    = '0;
      err_d        = ErrNone;
    end
  end

  always_comb begin
    res_o.out_byte     = b;
    res_o.section      = sec;
    res_o.header_index = in_hdr ? cnt_ext[7:0] : 8'd0;
    res_o.field_start  = fs;
    res_o.error_code   = err_n;
    res_o.request_done = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhMethod;
      cand_q       <= '1;
      pos_q        <= '0;
      is_opt_q     <= 1'b0;
      path_kind_q  <= 2'd0;
      saw_cr_q     <= 1'b0;
      line_empty_q <= 1'b1;
      hdr_cnt_q    <= '0;
      err_q        <= ErrNone;
    end else if (step_i) begin
      phase_q      <= phase_d;
      cand_q       <= cand_d;
      pos_q        <= pos_d;
      is_opt_q     <= is_opt_d;
      path_kind_q  <= path_kind_d;
      saw_cr_q     <= saw_cr_d;
      line_empty_q <= line_empty_d;
      hdr_cnt_q    <= hdr_cnt_d;
      err_q        <= err_d;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last |=> (phase_q == PhMethod) && (err_q == ErrNone) && (hdr_cnt_q == '0))
    else $error("request state not cleared after the last beat");

  a_err_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ErrNone) |-> (phase_q == PhDiscard))
    else $error("latched error outside the discard phase");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= MaxCnt)
    else $error("header count above the maximum");

  a_body_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == PhBody) && !last |=> (phase_q == PhBody) && !line_empty_q)
    else $error("body phase left before the last beat");

endmodule

`default_nettype wire

@@ src/http_request_head_parser.sv @@
// Top level of the HTTP/1.1 request head parser: handshake registers and header limit.
//
// Request bytes enter one per beat on the in channel (in_valid_i, in_stall_o,
// in_data_i). Each byte leaves on the out channel (out_valid_o, out_stall_i,
// out_data_o) tagged with its section, header line index, field start flag,
// the latched error code and a done flag on the request's last byte.
// A beat moves when valid is high and stall is low.
// A beat accepted into the input register stays there while the parse logic
// works on it, and its result is registered in the result register once that
// register is free; the receiver takes it from there. Throughput is one byte
// per cycle while the receiver does not stall; the parse state is a single
// register set updated as each byte passes into the result register.
// When the receiver stalls, the result register holds its beat and in_stall_o
// rises at once if the input register holds a byte; an empty input register
// takes one more byte first. The user writes the header limit with cfg_we_i
// and cfg_wdata_i while idle; the block itself does not enforce this. It is
// capped at MAX_HEADER_COUNT. Reset empties both registers, sets the limit to
// 256 and puts the parser at the start of a request. After each last byte the
// parse state returns to the start for the next request.
`default_nettype none

module http_request_head_parser import hrhp_pkg::*; #(
  parameter int unsigned MAX_HEADER_COUNT = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LimitW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire in_t               in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      out_t              out_data_o
);

  logic              in_vld_q;
  in_t               in_q;
  logic              out_vld_q;
  out_t              out_q;
  logic [LimitW-1:0] hdr_limit_q;
  logic              advance;
  logic              step;
  out_t              res;

  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign step       = in_vld_q && advance;

  hrhp_parser #(
    .MAX_HEADER_COUNT(MAX_HEADER_COUNT)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (in_q),
    .header_limit_i (hdr_limit_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      hdr_limit_q <= HdrLimitReset;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (cfg_we_i) begin
        hdr_limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
